### src/graph_matrix_shortest_path_engine_unit_assert.svh
// ============================================================================
// Graph engine assertion macros
// Concurrent check wrappers that compile away in synthesis builds.
// ============================================================================
`ifndef GRAPH_MATRIX_SHORTEST_PATH_ENGINE_UNIT_ASSERT_SVH
`define GRAPH_MATRIX_SHORTEST_PATH_ENGINE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// The condition holds at every clock edge outside reset.
`define GMSP_ASSERT_ALWAYS(name, clk, rst, cond) \
   name: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("graph engine check failed");
// The consequent holds in the same cycle as the antecedent.
`define GMSP_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("graph engine check failed");
// The consequent holds in the cycle after the antecedent.
`define GMSP_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("graph engine check failed");
`else
`define GMSP_ASSERT_ALWAYS(name, clk, rst, cond)
`define GMSP_ASSERT_IMPL(name, clk, rst, ante, cons)
`define GMSP_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

### src/gmsp_pkg.sv
// ============================================================================
// Graph engine package
// Shared widths, operation codes, controller states and matrix addressing.
// ============================================================================
`default_nettype none

package gmsp_pkg;

   localparam int MAX_V    = 16;
   localparam int VID_W    = 4;
   localparam int VCNT_W   = 5;
   localparam int ADDR_W   = 2 * VID_W;
   localparam int LABEL_W  = 16;
   localparam int KIND_W   = 3;
   localparam int WEIGHT_W = 8;
   localparam int DIST_W   = 12;
   localparam int ECNT_W   = 9;
   localparam int DEG2_W   = 5;
   localparam logic [DIST_W-1:0] DIST_INF = 12'd4095;

   typedef enum logic [KIND_W-1:0] {
      KIND_ADD    = 3'd0,
      KIND_DEL    = 3'd1,
      KIND_DIST   = 3'd2,
      KIND_PATH   = 3'd3,
      KIND_DEGREE = 3'd4,
      KIND_CLEAR  = 3'd5
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_EDGE_READ,
      ST_EDGE_UPDATE,
      ST_DIST_INIT,
      ST_DIST_SELECT,
      ST_DIST_RELAX,
      ST_DIST_READ,
      ST_BFS_PICK,
      ST_BFS_SCAN,
      ST_DEG_OUT,
      ST_DEG_IN,
      ST_FINISH
   } state_type;

   // Undirected graphs keep each edge at (smaller id, larger id).
   function automatic logic [ADDR_W-1:0] cell_addr(input logic [VID_W-1:0] x,
                                                   input logic [VID_W-1:0] y,
                                                   input logic directed);
      if (directed || (x < y)) return {x, y};
      else return {y, x};
   endfunction

endpackage

`default_nettype wire

### src/gmsp_req_if.sv
// ============================================================================
// Graph engine request channel
// Valid/ready channel carrying one operation per transaction.
// ============================================================================
`default_nettype none

interface gmsp_req_if import gmsp_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [LABEL_W-1:0]  first_label;
   logic [LABEL_W-1:0]  second_label;
   logic [WEIGHT_W-1:0] edge_weight;

   modport source (output valid, kind, first_label, second_label, edge_weight,
                   input ready);
   modport sink   (input valid, kind, first_label, second_label, edge_weight,
                   output ready);
endinterface

`default_nettype wire

### src/gmsp_rsp_if.sv
// ============================================================================
// Graph engine response channel
// Valid/ready channel carrying one result per transaction.
// ============================================================================
`default_nettype none

interface gmsp_rsp_if import gmsp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              ok;
   logic [DIST_W-1:0] result_value;
   logic [DEG2_W-1:0] second_value;
   logic [VCNT_W-1:0] vertex_count;
   logic [ECNT_W-1:0] edge_count;

   modport source (output valid, ok, result_value, second_value, vertex_count,
                   edge_count, input ready);
   modport sink   (input valid, ok, result_value, second_value, vertex_count,
                   edge_count, output ready);
endinterface

`default_nettype wire

### src/graph_matrix_shortest_path_engine_unit.sv
// ============================================================================
// Graph matrix shortest path engine
// Labeled graph in an adjacency matrix memory with distance, path and degree.
// ============================================================================
// Usage: each request transaction on req_bus carries one operation (add edge,
// delete edge, shortest distance, path test, degree, clear) and produces
// exactly one response transaction on rsp_bus. The csr_wr_en/csr_wr_data port
// selects directed or undirected edges; the user must write it only while
// idle, and the block itself does not enforce this.
// Scans stream one row of the weight matrix through the single read port of
// the matrix memory, one column per cycle. Degree needs one or two rows, the
// path test one row per reached vertex, and the shortest distance one
// selection pass over the distance table plus one row relaxation per settled
// vertex.
// One operation is in flight at a time; the next request is taken as soon as
// the result sits in the response register, even if it is not yet taken.
// Reset (synchronous, active high) empties the graph at once through a valid
// bit per matrix entry; no clearing pass is needed. When the receiver stalls,
// the response register holds its transaction and the engine waits in its
// final state until the register frees up.
// ============================================================================
`default_nettype none

`include "graph_matrix_shortest_path_engine_unit_assert.svh"

module graph_matrix_shortest_path_engine_unit import gmsp_pkg::*; (
   input  wire        clock,
   input  wire        reset,
   gmsp_req_if.sink   req_bus,
   gmsp_rsp_if.source rsp_bus,
   input  wire        csr_wr_en,
   input  wire        csr_wr_data
);

   // Operation registers.
   state_type            state_ff, state_in;
   kind_type             kind_ff;
   logic [LABEL_W-1:0]   la_ff, lb_ff;
   logic [WEIGHT_W-1:0]  wt_ff;
   logic                 dir_ff;

   // Graph bookkeeping.
   logic [LABEL_W-1:0]   label_ff [MAX_V];
   logic [VCNT_W-1:0]    used_ff, used_in;
   logic [ECNT_W-1:0]    edges_ff, edges_in;
   logic [VID_W-1:0]     u_ff, u_in, v_ff, v_in;
   logic                 u_hit_ff, u_hit_in, v_hit_ff, v_hit_in;

   // Weight matrix memory with a valid bit per entry.
   logic [WEIGHT_W-1:0]  wmem [MAX_V*MAX_V];
   logic [MAX_V*MAX_V-1:0] vld_ff;
   logic [WEIGHT_W-1:0]  rd_data_ff;
   logic                 rd_vld_ff;
   logic [ADDR_W-1:0]    rd_addr, wr_addr;
   logic                 wr_en, vld_clear;
   logic [WEIGHT_W-1:0]  wr_data;

   // Row scanner.
   logic [VCNT_W-1:0]    scan_idx_ff, scan_idx_in;
   logic                 scan_pend_ff, scan_pend_in;
   logic [VID_W-1:0]     scan_col_ff, scan_col_in;
   logic [VID_W-1:0]     scan_base_ff, scan_base_in;
   logic                 scan_active, scan_issue, scan_done;
   logic [WEIGHT_W-1:0]  w_ret;

   // Dijkstra and breadth-first state.
   logic [DIST_W-1:0]    dist_ff [MAX_V];
   logic                 dist_we;
   logic [VID_W-1:0]     dist_waddr, dist_raddr;
   logic [DIST_W-1:0]    dist_wdata, dist_rd;
   logic [MAX_V-1:0]     settled_ff, settled_in;
   logic [MAX_V-1:0]     visited_ff, visited_in;
   logic [MAX_V-1:0]     pend_ff, pend_in;
   logic                 any_ff, any_in;
   logic [DIST_W-1:0]    best_ff, best_in;
   logic [VID_W-1:0]     pick_ff, pick_in;
   logic [DIST_W:0]      relax_sum;
   logic [DIST_W-1:0]    relax_sat;

   // Label lookup and pending vertex search.
   logic                 a_hit, b_hit, p_any;
   logic [VID_W-1:0]     a_id, b_id, p_id;

   // Label table writes on vertex creation.
   logic                 lbl_we0, lbl_we1;
   logic [VID_W-1:0]     lbl_wa0, lbl_wa1;

   // Result and response registers.
   logic                 res_ok_ff, res_ok_in;
   logic [DIST_W-1:0]    res_r1_ff, res_r1_in;
   logic [DEG2_W-1:0]    res_r2_ff, res_r2_in;
   logic                 rsp_valid_ff, rsp_ok_ff;
   logic [DIST_W-1:0]    rsp_r1_ff;
   logic [DEG2_W-1:0]    rsp_r2_ff;
   logic [VCNT_W-1:0]    rsp_vc_ff;
   logic [ECNT_W-1:0]    rsp_ec_ff;
   logic                 req_take, out_free;

   // Add-edge helpers.
   logic                 present, la_eq_lb;
   logic [VCNT_W-1:0]    room;
   logic [1:0]           need;
   logic [VID_W-1:0]     nu, nv;

   assign req_take = req_bus.valid && req_bus.ready;
   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   assign req_bus.ready        = (state_ff == ST_IDLE);
   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.ok           = rsp_ok_ff;
   assign rsp_bus.result_value = rsp_r1_ff;
   assign rsp_bus.second_value = rsp_r2_ff;
   assign rsp_bus.vertex_count = rsp_vc_ff;
   assign rsp_bus.edge_count   = rsp_ec_ff;

   // Parallel label compare; the lowest matching slot wins.
   always_comb begin
      a_hit = 1'b0;
      b_hit = 1'b0;
      a_id  = '0;
      b_id  = '0;
      for (int i = MAX_V - 1; i >= 0; i--) begin
         if ((VCNT_W'(i) < used_ff) && (label_ff[i] == la_ff)) begin
            a_hit = 1'b1;
            a_id  = VID_W'(i);
         end
         if ((VCNT_W'(i) < used_ff) && (label_ff[i] == lb_ff)) begin
            b_hit = 1'b1;
            b_id  = VID_W'(i);
         end
      end
   end

   // Lowest pending vertex for the breadth-first search.
   always_comb begin
      p_any = 1'b0;
      p_id  = '0;
      for (int i = MAX_V - 1; i >= 0; i--) begin
         if (pend_ff[i]) begin
            p_any = 1'b1;
            p_id  = VID_W'(i);
         end
      end
   end

   // The scanner issues one column per cycle; its data returns in the following cycle.
   assign scan_active = (state_ff == ST_DIST_INIT) || (state_ff == ST_DIST_RELAX) ||
                        (state_ff == ST_BFS_SCAN) || (state_ff == ST_DEG_OUT) ||
                        (state_ff == ST_DEG_IN);
   assign scan_issue  = scan_active && (scan_idx_ff < used_ff);
   assign scan_done   = (scan_idx_ff >= used_ff) && !scan_pend_ff;
   assign w_ret       = rd_vld_ff ? rd_data_ff : '0;

   always_comb begin
      if (state_ff == ST_DEG_IN) begin
         rd_addr = cell_addr(scan_idx_ff[VID_W-1:0], scan_base_ff, dir_ff);
      end else if (state_ff == ST_EDGE_READ) begin
         rd_addr = cell_addr(u_ff, v_ff, dir_ff);
      end else begin
         rd_addr = cell_addr(scan_base_ff, scan_idx_ff[VID_W-1:0], dir_ff);
      end
   end

   // Distance table has one read port shared by selection, relaxation and
   // the final readout.
   always_comb begin
      if (state_ff == ST_DIST_RELAX) begin
         dist_raddr = scan_col_ff;
      end else if (state_ff == ST_DIST_READ) begin
         dist_raddr = v_ff;
      end else begin
         dist_raddr = scan_idx_ff[VID_W-1:0];
      end
   end
   assign dist_rd = dist_ff[dist_raddr];

   // Relaxation adds the settled vertex distance and saturates at infinity.
   assign relax_sum = {{(DIST_W + 1 - WEIGHT_W){1'b0}}, w_ret} + {1'b0, best_ff};
   assign relax_sat = (relax_sum > {1'b0, DIST_INF}) ? DIST_INF : relax_sum[DIST_W-1:0];

   // Vertex creation for add edge. Two missing endpoints always need two free slots, even with equal labels.
   assign present  = u_hit_ff && v_hit_ff && (w_ret != '0);
   assign la_eq_lb = (la_ff == lb_ff);
   assign room     = VCNT_W'(MAX_V) - used_ff;
   assign need     = (!u_hit_ff && !v_hit_ff) ? 2'd2 :
                     ((!u_hit_ff || !v_hit_ff) ? 2'd1 : 2'd0);
   assign nu       = u_hit_ff ? u_ff : used_ff[VID_W-1:0];
   always_comb begin
      if (v_hit_ff) begin
         nv = v_ff;
      end else if (u_hit_ff || la_eq_lb) begin
         nv = used_ff[VID_W-1:0];
      end else begin
         nv = used_ff[VID_W-1:0] + VID_W'(1);
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            unique case (kind_ff)
               KIND_ADD: begin
                  if (wt_ff == '0) state_in = ST_FINISH;
                  else if (a_hit && b_hit) state_in = ST_EDGE_READ;
                  else state_in = ST_EDGE_UPDATE;
               end
               KIND_DEL:    state_in = (a_hit && b_hit) ? ST_EDGE_READ : ST_FINISH;
               KIND_DIST:   state_in = (a_hit && b_hit) ? ST_DIST_INIT : ST_FINISH;
               KIND_PATH:   state_in = (a_hit && b_hit) ? ST_BFS_PICK : ST_FINISH;
               KIND_DEGREE: state_in = a_hit ? ST_DEG_OUT : ST_FINISH;
               default:     state_in = ST_FINISH;
            endcase
         end
         ST_EDGE_READ:   state_in = ST_EDGE_UPDATE;
         ST_EDGE_UPDATE: state_in = ST_FINISH;
         ST_DIST_INIT: begin
            if (scan_done) state_in = ST_DIST_SELECT;
         end
         ST_DIST_SELECT: begin
            if (scan_idx_ff >= used_ff) state_in = any_ff ? ST_DIST_RELAX : ST_DIST_READ;
         end
         ST_DIST_RELAX: begin
            if (scan_done) state_in = ST_DIST_SELECT;
         end
         ST_DIST_READ: state_in = ST_FINISH;
         ST_BFS_PICK:  state_in = p_any ? ST_BFS_SCAN : ST_FINISH;
         ST_BFS_SCAN: begin
            if (scan_done) state_in = ST_BFS_PICK;
         end
         ST_DEG_OUT: begin
            if (scan_done) state_in = dir_ff ? ST_DEG_IN : ST_FINISH;
         end
         ST_DEG_IN: begin
            if (scan_done) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and memory controls.
   always_comb begin
      used_in      = used_ff;
      edges_in     = edges_ff;
      u_in         = u_ff;
      v_in         = v_ff;
      u_hit_in     = u_hit_ff;
      v_hit_in     = v_hit_ff;
      scan_idx_in  = scan_idx_ff;
      scan_pend_in = 1'b0;
      scan_col_in  = scan_col_ff;
      scan_base_in = scan_base_ff;
      settled_in   = settled_ff;
      visited_in   = visited_ff;
      pend_in      = pend_ff;
      any_in       = any_ff;
      best_in      = best_ff;
      pick_in      = pick_ff;
      res_ok_in    = res_ok_ff;
      res_r1_in    = res_r1_ff;
      res_r2_in    = res_r2_ff;
      wr_en        = 1'b0;
      wr_addr      = cell_addr(nu, nv, dir_ff);
      wr_data      = wt_ff;
      vld_clear    = 1'b0;
      dist_we      = 1'b0;
      dist_waddr   = scan_col_ff;
      dist_wdata   = DIST_INF;
      lbl_we0      = 1'b0;
      lbl_we1      = 1'b0;
      lbl_wa0      = used_ff[VID_W-1:0];
      lbl_wa1      = nv;

      if (scan_issue) begin
         scan_idx_in  = scan_idx_ff + VCNT_W'(1);
         scan_pend_in = 1'b1;
         scan_col_in  = scan_idx_ff[VID_W-1:0];
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               res_ok_in = 1'b0;
               res_r1_in = '0;
               res_r2_in = '0;
            end
         end
         ST_LOOKUP: begin
            u_in         = a_id;
            v_in         = b_id;
            u_hit_in     = a_hit;
            v_hit_in     = b_hit;
            scan_base_in = a_id;
            scan_idx_in  = '0;
            unique case (kind_ff)
               KIND_DIST:   settled_in = '0;
               KIND_PATH: begin
                  visited_in       = '0;
                  pend_in          = '0;
                  pend_in[a_id]    = 1'b1;
               end
               KIND_DEGREE: res_ok_in = a_hit;
               KIND_CLEAR: begin
                  vld_clear = 1'b1;
                  used_in   = '0;
                  edges_in  = '0;
                  res_ok_in = 1'b1;
               end
               default: ;
            endcase
         end
         ST_EDGE_READ: ;
         ST_EDGE_UPDATE: begin
            if (kind_ff == KIND_ADD) begin
               if (!present && ({3'b000, need} <= room)) begin
                  wr_en     = 1'b1;
                  edges_in  = edges_ff + ECNT_W'(1);
                  res_ok_in = 1'b1;
                  lbl_we0   = !u_hit_ff;
                  lbl_we1   = !v_hit_ff && !(la_eq_lb && !u_hit_ff);
                  used_in   = used_ff + VCNT_W'(need);
                  if (!u_hit_ff && !v_hit_ff && la_eq_lb) used_in = used_ff + VCNT_W'(1);
               end
            end else if (w_ret != '0) begin
               wr_en     = 1'b1;
               wr_addr   = cell_addr(u_ff, v_ff, dir_ff);
               wr_data   = '0;
               edges_in  = edges_ff - ECNT_W'(1);
               res_ok_in = 1'b1;
               res_r1_in = {{(DIST_W - WEIGHT_W){1'b0}}, w_ret};
            end
         end
         ST_DIST_INIT: begin
            if (scan_pend_ff) begin
               dist_we    = 1'b1;
               dist_wdata = (w_ret != '0) ? {{(DIST_W - WEIGHT_W){1'b0}}, w_ret} : DIST_INF;
            end
            if (scan_done) begin
               dist_we          = 1'b1;
               dist_waddr       = u_ff;
               dist_wdata       = '0;
               settled_in[u_ff] = 1'b1;
               scan_idx_in      = '0;
               any_in           = 1'b0;
               best_in          = DIST_INF;
               pick_in          = '0;
            end
         end
         ST_DIST_SELECT: begin
            if (scan_idx_ff < used_ff) begin
               scan_idx_in = scan_idx_ff + VCNT_W'(1);
               if (!settled_ff[scan_idx_ff[VID_W-1:0]]) begin
                  any_in = 1'b1;
                  // Ties go to the highest id, so a later equal entry wins.
                  if (best_ff >= dist_rd) begin
                     pick_in = scan_idx_ff[VID_W-1:0];
                     best_in = dist_rd;
                  end
               end
            end else if (any_ff) begin
               settled_in[pick_ff] = 1'b1;
               scan_base_in        = pick_ff;
               scan_idx_in         = '0;
            end
         end
         ST_DIST_RELAX: begin
            if (scan_pend_ff && (w_ret != '0) && !settled_ff[scan_col_ff] &&
                (relax_sat < dist_rd)) begin
               dist_we    = 1'b1;
               dist_wdata = relax_sat;
            end
            if (scan_done) begin
               scan_idx_in = '0;
               any_in      = 1'b0;
               best_in     = DIST_INF;
               pick_in     = '0;
            end
         end
         ST_DIST_READ: begin
            res_r1_in = dist_rd;
            res_ok_in = 1'b1;
         end
         ST_BFS_PICK: begin
            if (p_any) begin
               pend_in[p_id] = 1'b0;
               scan_base_in  = p_id;
               scan_idx_in   = '0;
            end else begin
               res_ok_in = visited_ff[v_ff];
            end
         end
         ST_BFS_SCAN: begin
            if (scan_pend_ff && (w_ret != '0) && !visited_ff[scan_col_ff]) begin
               visited_in[scan_col_ff] = 1'b1;
               pend_in[scan_col_ff]    = 1'b1;
            end
         end
         ST_DEG_OUT: begin
            if (scan_pend_ff && (w_ret != '0)) res_r1_in = res_r1_ff + DIST_W'(1);
            if (scan_done) scan_idx_in = '0;
         end
         ST_DEG_IN: begin
            if (scan_pend_ff && (w_ret != '0)) res_r2_in = res_r2_ff + DEG2_W'(1);
         end
         ST_FINISH: ;
         default: ;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         dir_ff       <= 1'b0;
         used_ff      <= '0;
         edges_ff     <= '0;
         scan_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         edges_ff     <= edges_in;
         scan_pend_ff <= scan_pend_in;
         if (csr_wr_en) dir_ff <= csr_wr_data;
         if (state_ff == ST_FINISH && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_take) begin
         kind_ff <= kind_type'(req_bus.kind);
         la_ff   <= req_bus.first_label;
         lb_ff   <= req_bus.second_label;
         wt_ff   <= req_bus.edge_weight;
      end
      u_ff         <= u_in;
      v_ff         <= v_in;
      u_hit_ff     <= u_hit_in;
      v_hit_ff     <= v_hit_in;
      scan_idx_ff  <= scan_idx_in;
      scan_col_ff  <= scan_col_in;
      scan_base_ff <= scan_base_in;
      settled_ff   <= settled_in;
      visited_ff   <= visited_in;
      pend_ff      <= pend_in;
      any_ff       <= any_in;
      best_ff      <= best_in;
      pick_ff      <= pick_in;
      res_ok_ff    <= res_ok_in;
      res_r1_ff    <= res_r1_in;
      res_r2_ff    <= res_r2_in;
      if (dist_we) dist_ff[dist_waddr] <= dist_wdata;
      if (lbl_we0) label_ff[lbl_wa0] <= la_ff;
      if (lbl_we1) label_ff[lbl_wa1] <= lb_ff;
      if (state_ff == ST_FINISH && out_free) begin
         rsp_ok_ff <= res_ok_ff;
         rsp_r1_ff <= res_r1_ff;
         rsp_r2_ff <= res_r2_ff;
         rsp_vc_ff <= used_ff;
         rsp_ec_ff <= edges_ff;
      end
   end

   // Weight matrix memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) wmem[wr_addr] <= wr_data;
      rd_data_ff <= wmem[rd_addr];
   end

   // Entry valid bits; an entry that was never written reads as no edge.
   always_ff @(posedge clock) begin
      if (reset || vld_clear) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[wr_addr] <= 1'b1;
      end
      rd_vld_ff <= vld_ff[rd_addr];
   end

   `GMSP_ASSERT_ALWAYS(a_used_bound, clock, reset, used_ff <= VCNT_W'(MAX_V))
   `GMSP_ASSERT_IMPL(a_relax_settled, clock, reset, state_ff == ST_DIST_RELAX, settled_ff[scan_base_ff])
   `GMSP_ASSERT_NEXT(a_scan_return, clock, reset, scan_issue, scan_pend_ff)
   `GMSP_ASSERT_NEXT(a_finish_load, clock, reset, state_ff == ST_FINISH && out_free, rsp_valid_ff && state_ff == ST_IDLE)

endmodule

`default_nettype wire
